@@ hw/rtl/utf8pc_pkg.sv @@
package utf8pc_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int CNT_EXT_W   = COUNT_WIDTH + 1;
    localparam int OUT_W       = 32;
    localparam int NACC        = 4;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD_MIN2  = 8'hC2;
    localparam logic [7:0] LEAD_MIN3  = 8'hE0;
    localparam logic [7:0] LEAD_MIN4  = 8'hF0;
    localparam logic [7:0] LEAD_LIMIT = 8'hF5;
    localparam logic [7:0] LEAD_E0    = 8'hE0;
    localparam logic [7:0] LEAD_ED    = 8'hED;
    localparam logic [7:0] LEAD_F0    = 8'hF0;
    localparam logic [7:0] LEAD_F4    = 8'hF4;
    localparam logic [7:0] CONT_A0    = 8'hA0;
    localparam logic [7:0] CONT_90    = 8'h90;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_BYTE  = 2'd1,
        REQ_END   = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ENC_UTF8  = 2'd0,
        ENC_UTF16 = 2'd1,
        ENC_CP    = 2'd2
    } t_enc;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef struct packed {
        logic [2:0] n;
        logic [1:0] u16;
    } t_dec;

    typedef struct packed {
        logic [NACC-1:0]       valid;
        logic [NACC-1:0][2:0]  step;
        logic [NACC-1:0][2:0]  left;
        logic [2:0][7:0]       pend_bytes;
        logic [1:0]            pend_count;
    } t_drain;

    typedef struct packed {
        logic [OUT_W-1:0] total;
        logic             found;
        logic [OUT_W-1:0] offset;
    } t_result;

    // n = 0: sequence incomplete, wait for more bytes
    function automatic t_dec decode(input logic [3:0][7:0] w, input logic [2:0] avail,
                                    input logic fin);
        t_dec       res;
        logic [7:0] lead;
        logic [2:0] need;
        logic       ok;
        res.n   = 3'd1;
        res.u16 = 2'd1;
        lead    = w[0];
        need    = 3'd0;
        ok      = 1'b1;
        if (lead >= LEAD_MIN2 && lead < LEAD_LIMIT) begin
            if (lead < LEAD_MIN3) begin
                need = 3'd2;
            end else if (lead < LEAD_MIN4) begin
                need = 3'd3;
            end else begin
                need = 3'd4;
            end
            if (avail < need) begin
                res.n = fin ? 3'd1 : 3'd0;
            end else begin
                for (int j = 1; j < 4; j++) begin
                    if (3'(j) < need && (w[j] & CONT_MASK) != CONT_TAG) begin
                        ok = 1'b0;
                    end
                end
                if (lead == LEAD_E0 && w[1] < CONT_A0)  ok = 1'b0;
                if (lead == LEAD_ED && w[1] >= CONT_A0) ok = 1'b0;
                if (lead == LEAD_F0 && w[1] < CONT_90)  ok = 1'b0;
                if (lead == LEAD_F4 && w[1] >= CONT_90) ok = 1'b0;
                if (ok) begin
                    res.n   = need;
                    res.u16 = (need == 3'd4) ? 2'd2 : 2'd1;
                end
            end
        end
        return res;
    endfunction

    function automatic t_count sat_add(input t_count a, input logic [2:0] b);
        logic [CNT_EXT_W-1:0] s;
        s = {1'b0, a} + CNT_EXT_W'(b);
        return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input t_count v);
        logic [63:0] e;
        e = 64'(v);
        return (e > 64'hFFFF_FFFF) ? '1 : e[OUT_W-1:0];
    endfunction

endpackage

@@ hw/rtl/utf8pc_drain.sv @@
module utf8pc_drain import utf8pc_pkg::*; (
    input  logic [3:0][7:0] i_buf,
    input  logic [2:0]      i_len,
    input  logic            i_final,
    input  t_enc            i_enc,
    output t_drain          o_drain
);

    always_comb begin
        logic [2:0]      p;
        logic [2:0]      idx;
        logic            stop;
        logic [3:0][7:0] w;
        t_dec            dec;
        p       = 3'd0;
        stop    = 1'b0;
        w       = '0;
        dec     = '0;
        idx     = 3'd0;
        o_drain = '0;
        for (int k = 0; k < NACC; k++) begin
            for (int j = 0; j < 4; j++) begin
                idx  = p + 3'(j);
                w[j] = (idx < 3'd4) ? i_buf[idx[1:0]] : 8'h00;
            end
            if (!stop && p < i_len) begin
                dec = decode(w, i_len - p, i_final);
                if (dec.n == 3'd0) begin
                    stop = 1'b1;
                end else begin
                    o_drain.valid[k] = 1'b1;
                    case (i_enc)
                        ENC_UTF8:  o_drain.step[k] = dec.n;
                        ENC_UTF16: o_drain.step[k] = {1'b0, dec.u16};
                        default:   o_drain.step[k] = 3'd1;
                    endcase
                    o_drain.left[k] = i_len - p - dec.n;
                    p = p + dec.n;
                end
            end
        end
        for (int j = 0; j < 3; j++) begin
            idx = p + 3'(j);
            o_drain.pend_bytes[j] = (idx < 3'd4) ? i_buf[idx[1:0]] : 8'h00;
        end
        o_drain.pend_count = 2'(i_len - p);
    end

endmodule

@@ hw/rtl/utf8pc_tracker.sv @@
module utf8pc_tracker import utf8pc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_req        i_req,
    input  logic [7:0]  i_byte,
    input  logic [31:0] i_target,
    input  t_enc        i_enc,
    output t_result     o_result
);

    logic [2:0][7:0] r_pend_bytes, n_pend_bytes;
    logic [1:0]      r_pend_count, n_pend_count;
    t_count          r_byte_count, n_byte_count;
    t_count          r_unit_count, n_unit_count;
    logic [31:0]     r_target,     n_target;
    t_count          r_found_off,  n_found_off;
    logic            r_found,      n_found;
    logic            r_failed,     n_failed;

    logic [3:0][7:0] buf_w;
    logic [2:0]      len_w;
    logic            is_byte;
    t_drain          drn;

    assign is_byte = (i_req == REQ_BYTE);

    always_comb begin
        buf_w = {8'h00, r_pend_bytes};
        if (is_byte) begin
            buf_w[r_pend_count] = i_byte;
        end
        len_w = {1'b0, r_pend_count} + (is_byte ? 3'd1 : 3'd0);
    end

    utf8pc_drain u_drain (
        .i_buf   (buf_w),
        .i_len   (len_w),
        .i_final (!is_byte),
        .i_enc   (i_enc),
        .o_drain (drn)
    );

    always_comb begin
        t_count           bc_cur;
        logic [31:0]      gap;
        logic [2:0]       cum;
        logic [NACC-1:0][2:0] c;
        logic             hit;
        logic             hit_eq;
        logic [2:0]       hit_left;
        n_pend_bytes = r_pend_bytes;
        n_pend_count = r_pend_count;
        n_byte_count = r_byte_count;
        n_unit_count = r_unit_count;
        n_target     = r_target;
        n_found_off  = r_found_off;
        n_found      = r_found;
        n_failed     = r_failed;

        bc_cur = is_byte ? sat_add(r_byte_count, 3'd1) : r_byte_count;
        gap    = r_target - 32'(r_unit_count);
        cum    = 3'd0;
        c      = '0;
        for (int k = 0; k < NACC; k++) begin
            if (drn.valid[k]) cum = cum + drn.step[k];
            c[k] = cum;
        end
        hit      = 1'b0;
        hit_eq   = 1'b0;
        hit_left = 3'd0;
        for (int k = 0; k < NACC; k++) begin
            if (!hit && drn.valid[k] && 32'(c[k]) >= gap) begin
                hit      = 1'b1;
                hit_eq   = (32'(c[k]) == gap);
                hit_left = drn.left[k];
            end
        end

        if (i_fire) begin
            case (i_req)
                REQ_START: begin
                    n_pend_bytes = '0;
                    n_pend_count = 2'd0;
                    n_byte_count = '0;
                    n_unit_count = '0;
                    n_target     = i_target;
                    n_found_off  = '0;
                    n_found      = (i_target == 32'd0);
                    n_failed     = 1'b0;
                end
                REQ_BYTE, REQ_END: begin
                    n_pend_bytes = drn.pend_bytes;
                    n_pend_count = drn.pend_count;
                    n_byte_count = bc_cur;
                    n_unit_count = sat_add(r_unit_count, cum);
                    if (!r_found && !r_failed && hit) begin
                        if (hit_eq) begin
                            n_found     = 1'b1;
                            n_found_off = (bc_cur >= COUNT_WIDTH'(hit_left)) ?
                                          bc_cur - COUNT_WIDTH'(hit_left) : '0;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        logic ok;
        ok = 64'(r_target) <= 64'(r_byte_count);
        case (i_enc)
            ENC_UTF8: begin
                o_result.total  = sat_out(r_byte_count);
                o_result.found  = ok;
                o_result.offset = ok ? r_target : '0;
            end
            default: begin
                o_result.total  = sat_out(n_unit_count);
                o_result.found  = n_found;
                o_result.offset = n_found ? sat_out(n_found_off) : '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bytes <= '0;
            r_pend_count <= 2'd0;
            r_byte_count <= '0;
            r_unit_count <= '0;
            r_target     <= '0;
            r_found_off  <= '0;
            r_found      <= 1'b0;
            r_failed     <= 1'b0;
        end else begin
            r_pend_bytes <= n_pend_bytes;
            r_pend_count <= n_pend_count;
            r_byte_count <= n_byte_count;
            r_unit_count <= n_unit_count;
            r_target     <= n_target;
            r_found_off  <= n_found_off;
            r_found      <= n_found;
            r_failed     <= n_failed;
        end
    end

`ifndef SYNTH
    a_found_failed_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_found && r_failed))
        else $error("found and failed both set");

    a_search_below_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_found && !r_failed) |-> (64'(r_unit_count) <= 64'(r_target)))
        else $error("unit count passed target while searching");

    a_bytes_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req != REQ_START) |=> (r_byte_count >= $past(r_byte_count)))
        else $error("byte count decreased without start");
`endif

endmodule

@@ hw/rtl/utf8_position_converter.sv @@
// UTF-8 position converter. A string is sent as a start transaction (tuser 0,
// target position in tdata[39:8]), one transaction per text byte (tuser 1, byte
// in tdata[7:0]) and an end transaction (tuser 2), which alone yields a result:
// the string length in the configured units, a found flag and the byte offset of
// the target. Decoding is strict UTF-8; each bad or truncated byte counts as one
// code point of one unit. Throughput is one transaction per cycle while no end
// transaction is held off. A result is written to the result register when its
// end transaction leaves the input register. An end transaction waits in the
// input register, and holds off the input, while the result register still
// holds a result that has not been taken. The rate is set by the update of the
// decode and count state as each transaction leaves the input register.
module utf8_position_converter import utf8pc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // data_byte[7:0], target_units[39:8]
    input  logic [1:0]  i_s_axis_tuser,   // req_type[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // total_units[31:0], byte_offset[63:32]
    output logic [0:0]  o_m_axis_tuser    // offset_found[0]
);

    t_enc        r_enc,       n_enc;
    logic        r_in_valid,  n_in_valid;
    t_req        r_in_req,    n_in_req;
    logic [7:0]  r_in_byte,   n_in_byte;
    logic [31:0] r_in_target, n_in_target;
    logic        r_out_valid, n_out_valid;
    t_result     r_out,       n_out;

    logic        out_free;
    logic        proc;
    logic        s_accept;
    t_result     res;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign proc            = r_in_valid && (r_in_req != REQ_END || out_free);
    assign o_s_axis_tready = !r_in_valid || proc;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    utf8pc_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (proc),
        .i_req    (r_in_req),
        .i_byte   (r_in_byte),
        .i_target (r_in_target),
        .i_enc    (r_enc),
        .o_result (res)
    );

    always_comb begin
        n_enc       = r_enc;
        n_in_valid  = r_in_valid;
        n_in_req    = r_in_req;
        n_in_byte   = r_in_byte;
        n_in_target = r_in_target;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (i_cfg_valid) begin
            n_enc = t_enc'(i_cfg_data);
        end
        if (s_accept) begin
            n_in_valid  = 1'b1;
            n_in_req    = t_req'(i_s_axis_tuser);
            n_in_byte   = i_s_axis_tdata[7:0];
            n_in_target = i_s_axis_tdata[39:8];
        end else if (proc) begin
            n_in_valid = 1'b0;
        end
        if (proc && r_in_req == REQ_END) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc       <= ENC_UTF16;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_enc       <= n_enc;
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
        r_in_req    <= n_in_req;
        r_in_byte   <= n_in_byte;
        r_in_target <= n_in_target;
        r_out       <= n_out;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.offset, r_out.total};
    assign o_m_axis_tuser  = r_out.found;

`ifndef SYNTH
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc) |=> r_in_valid)
        else $error("stalled input transaction dropped");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_req == REQ_END) |=> r_out_valid)
        else $error("end transaction produced no result");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result transaction changed");
`endif

endmodule
